[rtl/cbpg_pkg.sv]
// Shared types and constants for the cubic Bezier point generator.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package cbpg_pkg;

   // Width of the segment count, point index and division remainder
   localparam int CNT_W = 6;
   // Width of t, u and the 65536 / N quotient (unsigned Q0.16 plus the 1.0 bit)
   localparam int QUO_W = 17;
   // Default clamp for the segment count
   localparam int DEF_MAX_SEGMENTS = 63;
   // Segment count after reset
   localparam logic [CNT_W-1:0] SEGMENTS_RESET = 6'd16;
   // t = 1.0 in Q0.16
   localparam logic [QUO_W-1:0] T_ONE = 17'h10000;
   // Depth of the queue between front and back
   localparam int Q_DEPTH = 2;

   // Four control points, signed Q2.14
   typedef struct packed {
      logic signed [15:0] p0_x;
      logic signed [15:0] p0_y;
      logic signed [15:0] p1_x;
      logic signed [15:0] p1_y;
      logic signed [15:0] p2_x;
      logic signed [15:0] p2_y;
      logic signed [15:0] p3_x;
      logic signed [15:0] p3_y;
   } cbpg_req_type;

   // One curve point
   typedef struct packed {
      logic [5:0]         point_index;
      logic signed [15:0] curve_x;
      logic signed [15:0] curve_y;
      logic               last_point;
   } cbpg_rsp_type;

   // Queued job: control points, segment count and the t step as quotient/remainder
   typedef struct packed {
      cbpg_req_type       pts;
      logic [CNT_W-1:0]   n;
      logic [QUO_W-1:0]   q;
      logic [CNT_W-1:0]   r;
   } cbpg_entry_type;

endpackage

`default_nettype wire

[rtl/cbpg_front.sv]
// Front end: segment count register, input acceptance and the serial divider
// that forms the t step 65536 / N. Depends on cbpg_pkg.
`default_nettype none

module cbpg_front import cbpg_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [CNT_W-1:0] csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbpg_req_type     req_data,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output cbpg_entry_type        push_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [CNT_W-1:0] segments_ff, segments_in;
   logic [1:0]       state_ff, state_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   cbpg_req_type     pts_ff, pts_in;
   logic [CNT_W-1:0] n_ff, n_in;

   logic [CNT_W-1:0] n_eff;
   logic [CNT_W:0]   shifted;
   logic             qbit;

   // Clamp the segment count: zero acts as one, large values stop at the limit
   always_comb begin
      if (segments_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(segments_ff) > MAX_SEGMENTS) begin
         n_eff = CNT_W'(MAX_SEGMENTS);
      end else begin
         n_eff = segments_ff;
      end
   end

   // One restoring division step; the dividend 65536 has only its top bit set
   always_comb begin
      shifted = {rem_ff, (cnt_ff == 5'(QUO_W - 1))};
      qbit    = (shifted >= {1'b0, n_ff});
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = '{pts: pts_ff, n: n_ff, q: quo_ff, r: rem_ff};

   // Sequence accept, divide and push
   always_comb begin
      segments_in = segments_ff;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      pts_in      = pts_ff;
      n_in        = n_ff;
      if (csr_write_en) begin
         segments_in = csr_write_data;
      end
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               pts_in   = req_data;
               n_in     = n_eff;
               quo_in   = '0;
               rem_in   = '0;
               cnt_in   = 5'(QUO_W - 1);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            quo_in = {quo_ff[QUO_W-2:0], qbit};
            if (qbit) begin
               rem_in = CNT_W'(shifted - {1'b0, n_ff});
            end else begin
               rem_in = shifted[CNT_W-1:0];
            end
            if (cnt_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEGMENTS_RESET;
         state_ff    <= F_IDLE;
      end else begin
         segments_ff <= segments_in;
         state_ff    <= state_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      pts_ff <= pts_in;
      n_ff   <= n_in;
   end

endmodule

`default_nettype wire

[rtl/cbpg_queue.sv]
// Short queue of jobs between the front end and the evaluation back end.
// Depends on cbpg_pkg.
`default_nettype none

module cbpg_queue import cbpg_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire cbpg_entry_type push_data,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output cbpg_entry_type      pop_data
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_QW = $clog2(Q_DEPTH + 1);

   cbpg_entry_type    slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_QW'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store an entry on push
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/cbpg_back.sv]
// Back end: steps t across the curve, forms the Bernstein weights on a shared
// multiplier, accumulates both coordinates and drives the result register.
// Depends on cbpg_pkg.
`default_nettype none

module cbpg_back import cbpg_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   input  wire cbpg_entry_type pop_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output cbpg_rsp_type        rsp_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_U2   = 4'd1;
   localparam logic [3:0] S_T2   = 4'd2;
   localparam logic [3:0] S_W0   = 4'd3;
   localparam logic [3:0] S_W1   = 4'd4;
   localparam logic [3:0] S_W2   = 4'd5;
   localparam logic [3:0] S_W3   = 4'd6;
   localparam logic [3:0] S_ACC3 = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   localparam int SQ_W  = 2 * QUO_W - 1;   // u^2, t^2 <= 2^32
   localparam int WT_W  = 3 * QUO_W - 2;   // weights <= 2^48
   localparam int MP_W  = SQ_W + QUO_W;
   localparam int ACC_W = 65;

   logic [3:0]              state_ff, state_in;
   cbpg_entry_type          ent_ff, ent_in;
   logic [QUO_W-1:0]        t_ff, t_in;
   logic [CNT_W-1:0]        r_ff, r_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [SQ_W-1:0]         u2_ff, u2_in;
   logic [SQ_W-1:0]         t2_ff, t2_in;
   logic [WT_W-1:0]         w_ff, w_in;
   logic signed [ACC_W-1:0] accx_ff, accx_in;
   logic signed [ACC_W-1:0] accy_ff, accy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cbpg_rsp_type            rsp_ff, rsp_in;

   logic [QUO_W-1:0]        u;
   logic [SQ_W-1:0]         mul_a;
   logic [QUO_W-1:0]        mul_b;
   logic [MP_W-1:0]         mul_p;
   logic [MP_W+1:0]         mul_p3;
   logic signed [15:0]      cx, cy;
   logic signed [ACC_W:0]   prod_x, prod_y;
   logic [CNT_W:0]          r_sum;
   logic                    is_last, out_free;

   // Round half up to Q2.14 and saturate
   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] biased;
      logic signed [16:0]      r;
      biased = acc + (ACC_W'(1) <<< 47);
      r      = biased[ACC_W-1:48];
      if (r > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (r < -17'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   assign u = T_ONE - t_ff;

   // Select operands of the shared weight multiplier
   always_comb begin
      mul_a = SQ_W'(u);
      mul_b = u;
      case (state_ff)
         S_U2: begin
            mul_a = SQ_W'(u);
            mul_b = u;
         end
         S_T2: begin
            mul_a = SQ_W'(t_ff);
            mul_b = t_ff;
         end
         S_W0: begin
            mul_a = u2_ff;
            mul_b = u;
         end
         S_W1: begin
            mul_a = u2_ff;
            mul_b = t_ff;
         end
         S_W2: begin
            mul_a = t2_ff;
            mul_b = u;
         end
         S_W3: begin
            mul_a = t2_ff;
            mul_b = t_ff;
         end
         default: begin
            mul_a = SQ_W'(u);
            mul_b = u;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign mul_p3 = {1'b0, mul_p, 1'b0} + (MP_W+2)'(mul_p);

   // Pick the control point that matches the weight held in w_ff
   always_comb begin
      cx = ent_ff.pts.p0_x;
      cy = ent_ff.pts.p0_y;
      case (state_ff)
         S_W2: begin
            cx = ent_ff.pts.p1_x;
            cy = ent_ff.pts.p1_y;
         end
         S_W3: begin
            cx = ent_ff.pts.p2_x;
            cy = ent_ff.pts.p2_y;
         end
         S_ACC3: begin
            cx = ent_ff.pts.p3_x;
            cy = ent_ff.pts.p3_y;
         end
         default: begin
            cx = ent_ff.pts.p0_x;
            cy = ent_ff.pts.p0_y;
         end
      endcase
   end

   assign prod_x = (ACC_W+1)'($signed({1'b0, w_ff})) * (ACC_W+1)'(cx);
   assign prod_y = (ACC_W+1)'($signed({1'b0, w_ff})) * (ACC_W+1)'(cy);

   assign r_sum    = {1'b0, r_ff} + {1'b0, ent_ff.r};
   assign is_last  = (idx_ff == ent_ff.n);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pop_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Step through one point per pass of the sequencer
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      u2_in        = u2_ff;
      t2_in        = t2_ff;
      w_in         = w_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               ent_in   = pop_data;
               t_in     = '0;
               r_in     = '0;
               idx_in   = '0;
               state_in = S_U2;
            end
         end
         S_U2: begin
            u2_in    = mul_p[SQ_W-1:0];
            state_in = S_T2;
         end
         S_T2: begin
            t2_in    = mul_p[SQ_W-1:0];
            state_in = S_W0;
         end
         S_W0: begin
            w_in     = mul_p[WT_W-1:0];
            state_in = S_W1;
         end
         S_W1: begin
            w_in     = mul_p3[WT_W-1:0];
            accx_in  = prod_x[ACC_W-1:0];
            accy_in  = prod_y[ACC_W-1:0];
            state_in = S_W2;
         end
         S_W2: begin
            w_in     = mul_p3[WT_W-1:0];
            accx_in  = accx_ff + prod_x[ACC_W-1:0];
            accy_in  = accy_ff + prod_y[ACC_W-1:0];
            state_in = S_W3;
         end
         S_W3: begin
            w_in     = mul_p[WT_W-1:0];
            accx_in  = accx_ff + prod_x[ACC_W-1:0];
            accy_in  = accy_ff + prod_y[ACC_W-1:0];
            state_in = S_ACC3;
         end
         S_ACC3: begin
            accx_in  = accx_ff + prod_x[ACC_W-1:0];
            accy_in  = accy_ff + prod_y[ACC_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register frees up
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.point_index = 6'(idx_ff);
               rsp_in.curve_x     = round_sat(accx_ff);
               rsp_in.curve_y     = round_sat(accy_ff);
               rsp_in.last_point  = is_last;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  // Advance t by 65536 / N, carrying the remainder
                  if (r_sum >= {1'b0, ent_ff.n}) begin
                     r_in = CNT_W'(r_sum - {1'b0, ent_ff.n});
                     t_in = t_ff + ent_ff.q + QUO_W'(1);
                  end else begin
                     r_in = r_sum[CNT_W-1:0];
                     t_in = t_ff + ent_ff.q;
                  end
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_U2;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff  <= ent_in;
      t_ff    <= t_in;
      r_ff    <= r_in;
      idx_ff  <= idx_in;
      u2_ff   <= u2_in;
      t2_ff   <= t2_in;
      w_ff    <= w_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

[rtl/cubic_bezier_point_generator.sv]
// Cubic Bezier point generator: one set of four control points in, N+1 points out.
// Front: accept, serial divide and push per set, forming the t step 65536 / N.
// Back: one point per pass of its states (U2, T2, W0-W3, ACC3, OUT) on a shared
// multiplier; the front prepares the next set meanwhile (2-deep queue).
// Reset (synchronous): segment count 16, queue empty, no result pending.
`default_nettype none

module cubic_bezier_point_generator import cbpg_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [CNT_W-1:0] csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbpg_req_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cbpg_rsp_type          rsp_data
);

   logic           q_push_valid, q_push_ready;
   cbpg_entry_type q_push_data;
   logic           q_pop_valid, q_pop_ready;
   cbpg_entry_type q_pop_data;

   cbpg_front #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .push_valid     (q_push_valid),
      .push_ready     (q_push_ready),
      .push_data      (q_push_data)
   );

   cbpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   cbpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // No result is pending right after reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A full queue is never empty
   a_queue_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      !q_push_ready |-> q_pop_valid)
      else $error("queue occupancy inconsistent");

   // Points before the last one stay below the segment limit
   a_index_below_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_point |-> rsp_data.point_index < 6'(MAX_SEGMENTS))
      else $error("non-final point index at or above segment limit");

   // The transaction after a final point starts a new curve at index zero
   a_new_curve_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_point |=>
         !rsp_valid || rsp_data.point_index == '0)
      else $error("curve did not restart at index zero");

endmodule

`default_nettype wire

[tb/cubic_bezier_point_generator_tb.sv]
// Self-checking testbench for the cubic Bezier point generator: control point sets in,
// N+1 curve points out, compared against an in-bench fixed-point curve evaluator.
// Depends on cbpg_pkg and the cubic_bezier_point_generator RTL.
`default_nettype none

module cubic_bezier_point_generator_tb;
   import cbpg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 600;
   localparam int RANDOM_SETS  = 12;
   localparam int HOLD_SET     = 3;

   // Expected curve points and the evaluator that produces them
   class curve_scoreboard;
      logic [CNT_W-1:0] seg_count;
      cbpg_rsp_type     expected_points[$];
      int               errors;

      function new();
         seg_count = SEGMENTS_RESET;
         errors    = 0;
      endfunction

      function void set_segments(logic [CNT_W-1:0] value);
         seg_count = value;
      endfunction

      function int outstanding();
         return expected_points.size();
      endfunction

      // Weighted sum in Q2.62 (Q0.48 weights times Q2.14 points), round half up to Q2.14, then saturate
      function logic signed [15:0] bezier_coord(longint c0, longint c1, longint c2,
                                                longint c3, longint u, longint t);
         longint acc;
         longint r;
         acc = u * u * u * c0 + 3 * u * u * t * c1 + 3 * u * t * t * c2
               + t * t * t * c3;
         acc = acc + (64'sd1 <<< 47);
         r = acc >>> 48;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r[15:0];
      endfunction

      function void add_control_points(cbpg_req_type pts);
         int           n;
         longint       t;
         longint       u;
         cbpg_rsp_type pt;
         n = int'(seg_count);
         if (n < 1) n = 1;
         if (n > DEF_MAX_SEGMENTS) n = DEF_MAX_SEGMENTS;
         for (int i = 0; i <= n; i++) begin
            t = (longint'(i) << 16) / longint'(n);
            u = 65536 - t;
            pt.point_index = i[CNT_W-1:0];
            pt.curve_x = bezier_coord(longint'(pts.p0_x), longint'(pts.p1_x),
                                      longint'(pts.p2_x), longint'(pts.p3_x), u, t);
            pt.curve_y = bezier_coord(longint'(pts.p0_y), longint'(pts.p1_y),
                                      longint'(pts.p2_y), longint'(pts.p3_y), u, t);
            pt.last_point = (i == n);
            expected_points.insert(expected_points.size(), pt);
         end
      endfunction

      function void check_curve_point(cbpg_rsp_type got);
         cbpg_rsp_type want;
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected point: idx=%0d x=%0d y=%0d last=%0b",
                        got.point_index, got.curve_x, got.curve_y, got.last_point);
            return;
         end
         want = expected_points.pop_front();
         if (got.point_index !== want.point_index || got.curve_x !== want.curve_x ||
             got.curve_y !== want.curve_y || got.last_point !== want.last_point) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: want idx=%0d x=%0d y=%0d last=%0b got %0d %0d %0d %0b",
                        want.point_index, want.curve_x, want.curve_y, want.last_point,
                        got.point_index, got.curve_x, got.curve_y, got.last_point);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [CNT_W-1:0] csr_write_data;
   logic             req_valid;
   logic             req_ready;
   cbpg_req_type     req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cbpg_rsp_type     rsp_data;

   curve_scoreboard  sb;
   int               idle_cycles;
   int               burst_left;
   bit               hold_req;
   bit               hold_done = 1'b0;
   int               hold_left = 0;
   int               stall_mode = 0;
   int               stretch_left = 0;
   int unsigned      ready_tick = 0;

   cubic_bezier_point_generator DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stretches of always-ready, random and sparse ready, plus one long hold
   always @(posedge clock) begin
      ready_tick++;
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (stretch_left == 0) begin
         stall_mode   = $urandom_range(0, 3);
         stretch_left = $urandom_range(5, 60);
      end
      stretch_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (ready_tick % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Observe transactions on both channels; stop if nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && req_ready) sb.add_control_points(req_data);
         if (rsp_valid && rsp_ready) sb.check_curve_point(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic cbpg_req_type make_points(logic [15:0] ax, logic [15:0] ay,
                                                logic [15:0] bx, logic [15:0] by,
                                                logic [15:0] cx, logic [15:0] cy,
                                                logic [15:0] dx, logic [15:0] dy);
      cbpg_req_type pts;
      pts.p0_x = ax; pts.p0_y = ay;
      pts.p1_x = bx; pts.p1_y = by;
      pts.p2_x = cx; pts.p2_y = cy;
      pts.p3_x = dx; pts.p3_y = dy;
      return pts;
   endfunction

   // Mostly full-range coordinates, some extremes, some near zero
   function automatic logic [15:0] random_coord(int flavor);
      logic [15:0] v;
      case (flavor)
         0: begin
            case ($urandom_range(0, 3))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               default: v = 16'hFFFF;
            endcase
         end
         1: v = 16'($urandom_range(0, 128) - 64);
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic cbpg_req_type random_points();
      int flavor;
      int pick;
      pick = $urandom_range(0, 99);
      flavor = (pick < 15) ? 0 : (pick < 30) ? 1 : 2;
      return make_points(random_coord(flavor), random_coord(flavor),
                         random_coord(flavor), random_coord(flavor),
                         random_coord(flavor), random_coord(flavor),
                         random_coord(flavor), random_coord(flavor));
   endfunction

   // Hold valid and payload until the transaction is accepted
   task automatic offer_points(input cbpg_req_type pts);
      req_valid <= 1'b1;
      req_data  <= pts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // With gaps on, send in bursts of random length with random gaps between them
   task automatic send_points(input cbpg_req_type pts, input bit gaps_on);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      offer_points(pts);
      if (burst_left > 0) burst_left--;
   endtask

   // Drop valid and wait for every expected point to arrive
   task automatic drain_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_segments(input logic [CNT_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_segments(value);
      @(posedge clock);
   endtask

   initial begin
      int seg_list [RANDOM_SETS];
      int set_count;
      bit gaps_on;

      seg_list = '{3, 0, 7, 2, 63, 1, 5, 16, 4, 31, 6, 8};
      sb = new();
      hold_req       = 1'b0;
      burst_left     = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets at the reset segment count
      send_points(make_points(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
      send_points(make_points(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b1);
      send_points(make_points(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1);
      send_points(make_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                              16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF), 1'b1);
      send_points(make_points(16'h8000, 16'h8000, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF), 1'b1);
      send_points(make_points(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                              16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555), 1'b1);
      send_points(make_points(16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE,
                              16'h4000, 16'hC000, 16'h0100, 16'hFF00), 1'b1);
      send_points(make_points(0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0), 1'b1);
      drain_points();

      // Zero segments behaves as one segment
      write_segments(6'd0);
      send_points(make_points(16'h1234, 16'hEDCB, 0, 0, 0, 0, 16'h7FFF, 16'h8000), 1'b1);
      send_points(make_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                              16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000), 1'b1);
      drain_points();

      // Midpoint landing exactly on a half step: rounds toward plus infinity
      write_segments(6'd2);
      send_points(make_points(16'd4, 16'hFFFC, 0, 0, 0, 0, 0, 0), 1'b1);
      send_points(make_points(16'd12, 16'hFFF4, 0, 0, 0, 0, 16'd4, 16'hFFFC), 1'b1);
      drain_points();

      // Largest segment count
      write_segments(6'd63);
      send_points(make_points(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                              16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF), 1'b1);
      send_points(random_points(), 1'b1);
      drain_points();

      write_segments(6'd1);
      send_points(make_points(16'h7FFF, 16'h8000, 16'h1111, 16'h2222,
                              16'h3333, 16'h4444, 16'h8000, 16'h7FFF), 1'b1);
      drain_points();

      // Random sets, one segment count per phase; one phase runs against a long hold
      for (int p = 0; p < RANDOM_SETS; p++) begin
         write_segments(seg_list[p][CNT_W-1:0]);
         set_count = (seg_list[p] >= 16) ? 10 : 44;
         gaps_on   = (p % 3 != 0);
         if (p == HOLD_SET) begin
            hold_req = 1'b1;
            gaps_on  = 1'b0;
         end
         for (int k = 0; k < set_count; k++)
            send_points(random_points(), gaps_on);
         drain_points();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
